// ===== design/tlbf_pkg.sv =====
`default_nettype none
package tlbf_pkg;
  localparam int unsigned MaxWidthDef  = 256;
  localparam int unsigned MaxHeightDef = 256;
  localparam int unsigned MaxLinesDef  = 32;
  localparam int unsigned CfgW         = 9;
  localparam int unsigned CfgIdxW      = 3;

  localparam logic [CfgIdxW-1:0] RegLineThr = 3'd0;
  localparam logic [CfgIdxW-1:0] RegColThr  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMinH    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegWidth   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegHeight  = 3'd4;

  typedef struct packed {
    logic load;      // pixel transfer accepted
    logic trim_init; // start trimming box at index
    logic left_step; // step left edge past a light column
    logic right_step;
    logic col_clr;   // clear column accumulator, set y = top
    logic col_acc;   // accumulate one map read
    logic frame_clr;
  } tlbf_cmd_t;

  typedef struct packed {
    logic frame_end; // current transfer ends frame
    logic no_boxes;
    logic col_done;  // y reached bottom (or past map)
    logic col_light;
    logic left_more; // left < w
    logic right_more;// right > left
    logic last_box;
  } tlbf_sts_t;
endpackage
`default_nettype wire

// ===== design/tlbf_datapath.sv =====
`default_nettype none
module tlbf_datapath #(
  parameter int unsigned MaxWidth  = tlbf_pkg::MaxWidthDef,
  parameter int unsigned MaxHeight = tlbf_pkg::MaxHeightDef,
  parameter int unsigned MaxLines  = tlbf_pkg::MaxLinesDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [tlbf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [tlbf_pkg::CfgW-1:0] cfg_data_i,
  input  wire logic dark_i,
  input  wire tlbf_pkg::tlbf_cmd_t cmd_i,
  input  wire logic [$clog2(MaxLines+1)-1:0] box_k_i,
  output tlbf_pkg::tlbf_sts_t sts_o,
  output logic [$clog2(MaxLines+1)-1:0] box_count_o,
  output logic [7:0] box_top_o,
  output logic [8:0] box_bottom_o,
  output logic [8:0] box_left_o,
  output logic [8:0] box_right_o,
  output logic box_overflow_o
);
  localparam int unsigned XW = $clog2(MaxWidth);
  localparam int unsigned YW = $clog2(MaxHeight);
  localparam int unsigned DW = XW + 1;
  localparam int unsigned HW = YW + 1;
  localparam int unsigned KW = $clog2(MaxLines+1);
  localparam int unsigned IW = (MaxLines > 1) ? $clog2(MaxLines) : 1;
  localparam int unsigned AW = XW + YW;
  localparam int unsigned CW = 16;

  logic [8:0] lthr_q, cthr_q, minh_q, fw_q, fh_q;
  logic [DW-1:0] w;
  logic [HW-1:0] h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lthr_q <= '0; cthr_q <= '0; minh_q <= 9'd5; fw_q <= 9'd256; fh_q <= 9'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tlbf_pkg::RegLineThr: lthr_q <= cfg_data_i;
        tlbf_pkg::RegColThr:  cthr_q <= cfg_data_i;
        tlbf_pkg::RegMinH:    minh_q <= cfg_data_i;
        tlbf_pkg::RegWidth:   fw_q   <= cfg_data_i;
        tlbf_pkg::RegHeight:  fh_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fw_q == '0) w = DW'(1);
    else if (32'(fw_q) > MaxWidth) w = DW'(MaxWidth);
    else w = DW'(fw_q);
    if (fh_q == '0) h = HW'(1);
    else if (32'(fh_q) > MaxHeight) h = HW'(MaxHeight);
    else h = HW'(fh_q);
  end

  logic [XW-1:0] col_q;
  logic [YW-1:0] row_q, lstart_q;
  logic [DW-1:0] rcnt_q;
  logic inl_q, drop_q;
  logic [KW-1:0] bcnt_q;
  logic [7:0] rows_top [MaxLines];
  logic [8:0] rows_bot [MaxLines];
  logic [DW-1:0] rcnt_n;
  logic row_end, frm_end, row_dark, row_close;
  logic [HW-1:0] lh;
  logic [18:0] row_lim;

  // floor(cnt*256/w) > thr  <=>  cnt*256 >= (thr+1)*w
  assign row_lim = 19'({1'b0, lthr_q} + 10'd1) * 19'(w);
  assign rcnt_n  = rcnt_q + DW'(dark_i);
  assign row_end = (32'(col_q) + 1) >= 32'(w);
  assign frm_end = row_end && ((32'(row_q) + 1) >= 32'(h));
  assign row_dark = (32'(rcnt_n) << 8) >= 32'(row_lim);
  assign lh = HW'(row_q) - HW'(lstart_q);
  assign row_close = !row_dark && inl_q && (32'(lh) >= 32'(minh_q));

  logic [7:0] cur_top_q;
  logic [8:0] cur_bot_q;
  logic [DW-1:0] left_q, right_q;
  logic [YW:0] y_q;
  logic [CW-1:0] ccnt_q;
  logic [XW-1:0] tcol;
  logic [AW-1:0] raddr;
  logic rd_q, acc_q, past_q;
  logic [8:0] bh;
  logic [18:0] col_lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0; row_q <= '0; rcnt_q <= '0; inl_q <= 1'b0; lstart_q <= '0;
      bcnt_q <= '0; drop_q <= 1'b0;
    end else if (cmd_i.frame_clr) begin
      col_q <= '0; row_q <= '0; rcnt_q <= '0; inl_q <= 1'b0; lstart_q <= '0;
      bcnt_q <= '0; drop_q <= 1'b0;
    end else if (cmd_i.load) begin
      if (!row_end) begin
        col_q <= col_q + XW'(1);
        rcnt_q <= rcnt_n;
      end else begin
        col_q <= '0;
        rcnt_q <= '0;
        if (row_dark) begin
          if (!inl_q) begin inl_q <= 1'b1; lstart_q <= row_q; end
        end else if (inl_q) begin
          inl_q <= 1'b0;
          if (row_close) begin
            if (32'(bcnt_q) < MaxLines) bcnt_q <= bcnt_q + KW'(1);
            else drop_q <= 1'b1;
          end
        end
        if (!frm_end) row_q <= row_q + YW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && row_end && row_close && 32'(bcnt_q) < MaxLines) begin
      rows_top[IW'(bcnt_q)] <= 8'(lstart_q);
      rows_bot[IW'(bcnt_q)] <= 9'(row_q);
    end
  end

  logic dmap [2**AW];
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) dmap[{row_q, col_q}] <= dark_i;
    rd_q <= dmap[raddr];
  end

  // trimming: column count walks y from top to bottom, one bit a cycle
  assign tcol  = past_q ? XW'(right_q - DW'(1)) : left_q[XW-1:0];
  assign raddr = {y_q[YW-1:0], tcol};
  assign bh = cur_bot_q - {1'b0, cur_top_q};
  assign col_lim = 19'({1'b0, cthr_q} + 10'd1) * 19'(bh);

  // past_q: left scan finished, columns now taken from the right
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      past_q <= 1'b0; acc_q <= 1'b0;
    end else begin
      acc_q <= cmd_i.col_acc;
      if (cmd_i.trim_init) past_q <= 1'b0;
      else if (cmd_i.left_step && !sts_o.col_light) past_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.trim_init) begin
      cur_top_q <= rows_top[IW'(box_k_i)];
      cur_bot_q <= rows_bot[IW'(box_k_i)];
      left_q <= '0;
      right_q <= w;
    end
    if (cmd_i.col_clr) begin
      y_q <= (YW+1)'(cur_top_q);
      ccnt_q <= '0;
    end else begin
      if (cmd_i.col_acc) y_q <= y_q + (YW+1)'(1);
      if (acc_q) ccnt_q <= ccnt_q + CW'(rd_q);
    end
    if (cmd_i.left_step && sts_o.col_light) left_q <= left_q + DW'(1);
    if (cmd_i.right_step && sts_o.col_light) right_q <= right_q - DW'(1);
  end

  always_comb begin
    sts_o.frame_end  = frm_end;
    sts_o.no_boxes   = (bcnt_q == '0);
    sts_o.col_done   = (32'(y_q) >= 32'(cur_bot_q)) || (32'(y_q) >= MaxHeight);
    sts_o.col_light  = (bh == '0) || ((32'(ccnt_q) << 8) < 32'(col_lim));
    sts_o.left_more  = left_q < w;
    sts_o.right_more = right_q > left_q;
    sts_o.last_box   = (box_k_i + KW'(1)) == bcnt_q;
  end

  assign box_count_o    = bcnt_q;
  assign box_top_o      = cur_top_q;
  assign box_bottom_o   = cur_bot_q;
  assign box_left_o     = 9'(left_q);
  assign box_right_o    = 9'(right_q);
  assign box_overflow_o = drop_q;
endmodule
`default_nettype wire

// ===== design/tlbf_ctrl.sv =====
`default_nettype none
module tlbf_ctrl #(
  parameter int unsigned MaxLines = tlbf_pkg::MaxLinesDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  wire logic out_stall_i,
  input  wire tlbf_pkg::tlbf_sts_t sts_i,
  output tlbf_pkg::tlbf_cmd_t cmd_o,
  output logic [$clog2(MaxLines+1)-1:0] box_k_o,
  output logic valid_mark_o,
  output logic last_mark_o
);
  localparam int unsigned KW = $clog2(MaxLines+1);
  typedef enum logic [7:0] {
    S_LOAD  = 8'b00000001,
    S_INIT  = 8'b00000010,
    S_LCLR  = 8'b00000100,
    S_LACC  = 8'b00001000,
    S_RCLR  = 8'b00010000,
    S_RACC  = 8'b00100000,
    S_EMIT  = 8'b01000000,
    S_NONE  = 8'b10000000
  } state_e;

  state_e st_q, st_d;
  logic [KW-1:0] k_q, k_d;
  logic wait_q, wait_d; // waits for the last read to land

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_LOAD; k_q <= '0; wait_q <= 1'b0;
    end else begin
      st_q <= st_d; k_q <= k_d; wait_q <= wait_d;
    end
  end

  logic acc;
  assign acc = in_valid_i && (st_q == S_LOAD);

  always_comb begin
    st_d = st_q; k_d = k_q; wait_d = 1'b0;
    cmd_o = '0;
    out_valid_o = 1'b0;
    valid_mark_o = 1'b0;
    last_mark_o = 1'b0;
    in_stall_o = (st_q != S_LOAD);
    unique case (st_q)
      S_LOAD: begin
        cmd_o.load = acc;
        if (acc && sts_i.frame_end) begin
          k_d = '0;
          st_d = S_INIT;
        end
      end
      S_INIT: begin
        if (sts_i.no_boxes) st_d = S_NONE;
        else begin cmd_o.trim_init = 1'b1; st_d = S_LCLR; end
      end
      S_LCLR: begin
        if (!sts_i.left_more) st_d = S_RCLR;
        else begin cmd_o.col_clr = 1'b1; st_d = S_LACC; end
      end
      S_LACC: begin
        if (!sts_i.col_done) cmd_o.col_acc = 1'b1;
        else if (!wait_q) wait_d = 1'b1;
        else begin
          cmd_o.left_step = 1'b1;
          st_d = sts_i.col_light ? S_LCLR : S_RCLR;
        end
        wait_d = sts_i.col_done && !wait_q;
      end
      S_RCLR: begin
        if (!sts_i.right_more) st_d = S_EMIT;
        else begin cmd_o.col_clr = 1'b1; cmd_o.right_step = 1'b0; st_d = S_RACC; end
      end
      S_RACC: begin
        if (!sts_i.col_done) cmd_o.col_acc = 1'b1;
        else if (wait_q) begin
          cmd_o.right_step = 1'b1;
          st_d = sts_i.col_light ? S_RCLR : S_EMIT;
        end
        wait_d = sts_i.col_done && !wait_q;
      end
      S_EMIT: begin
        out_valid_o = 1'b1;
        valid_mark_o = 1'b1;
        last_mark_o = sts_i.last_box;
        if (!out_stall_i) begin
          if (sts_i.last_box) begin
            cmd_o.frame_clr = 1'b1; st_d = S_LOAD;
          end else begin
            k_d = k_q + KW'(1); st_d = S_INIT;
          end
        end
      end
      S_NONE: begin
        out_valid_o = 1'b1;
        last_mark_o = 1'b1;
        if (!out_stall_i) begin cmd_o.frame_clr = 1'b1; st_d = S_LOAD; end
      end
      default: st_d = S_LOAD;
    endcase
  end

  assign box_k_o = k_q;
endmodule
`default_nettype wire

// ===== design/text_line_box_finder_top.sv =====
// Text line box finder.
// Pixel channel: in_valid_i/in_stall_o with red_i, green_i, blue_i, one
// pixel per transfer in raster order, one pixel a cycle while loading.
// A pixel is dark unless all channels are 255; dark bits go to a map memory.
// Lines are found at each row end. After the last pixel of a frame the pixel
// channel stalls while each box is trimmed: the box is loaded, then every
// tested column is read one map bit a cycle through the single map read
// port. Boxes then leave on out_valid_o/out_stall_i, one per transfer, in
// order of top row; an empty frame gives one result with box_valid_o low.
// The result holds while the receiver stalls, and the next box is not
// trimmed until the current one is taken. Configuration: cfg_we_i,
// cfg_idx_i, cfg_data_i, written by the user only while idle; the block
// does not enforce it. Reset clears counters and registers to defaults;
// the map needs no clear.
`default_nettype none
module text_line_box_finder_top #(
  parameter int unsigned MaxWidth  = tlbf_pkg::MaxWidthDef,
  parameter int unsigned MaxHeight = tlbf_pkg::MaxHeightDef,
  parameter int unsigned MaxLines  = tlbf_pkg::MaxLinesDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [tlbf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [tlbf_pkg::CfgW-1:0] cfg_data_i,
  input  wire logic in_valid_i,
  output logic in_stall_o,
  input  wire logic [7:0] red_i,
  input  wire logic [7:0] green_i,
  input  wire logic [7:0] blue_i,
  output logic out_valid_o,
  input  wire logic out_stall_i,
  output logic [7:0] box_top_o,
  output logic [8:0] box_bottom_o,
  output logic [8:0] box_left_o,
  output logic [8:0] box_right_o,
  output logic box_valid_o,
  output logic box_overflow_o,
  output logic box_last_o
);
  localparam int unsigned KW = $clog2(MaxLines+1);
  tlbf_pkg::tlbf_cmd_t cmd;
  tlbf_pkg::tlbf_sts_t sts;
  logic [KW-1:0] k, bcnt;
  logic vmark;
  logic [7:0] t; logic [8:0] b, l, r; logic ov;
  logic dark;
  assign dark = !((red_i == 8'hFF) && (green_i == 8'hFF) && (blue_i == 8'hFF));

  tlbf_ctrl #(.MaxLines(MaxLines)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd), .box_k_o(k), .valid_mark_o(vmark),
    .last_mark_o(box_last_o)
  );

  tlbf_datapath #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight), .MaxLines(MaxLines)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .dark_i(dark),
    .cmd_i(cmd), .box_k_i(k), .sts_o(sts), .box_count_o(bcnt),
    .box_top_o(t), .box_bottom_o(b), .box_left_o(l), .box_right_o(r),
    .box_overflow_o(ov)
  );

  assign box_valid_o    = vmark && (bcnt != '0);
  assign box_top_o      = vmark ? t : 8'd0;
  assign box_bottom_o   = vmark ? b : 9'd0;
  assign box_left_o     = vmark ? l : 9'd0;
  assign box_right_o    = vmark ? r : 9'd0;
  assign box_overflow_o = vmark ? ov : 1'b0;
endmodule
`default_nettype wire

// ===== verif/text_line_box_finder_top_tb.sv =====
`default_nettype none
module text_line_box_finder_top_tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [tlbf_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [tlbf_pkg::CfgW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [7:0] red_i = '0, green_i = '0, blue_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] box_top_o;
  logic [8:0] box_bottom_o, box_left_o, box_right_o;
  logic box_valid_o, box_overflow_o, box_last_o;

  text_line_box_finder_top i_dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  typedef struct packed {
    logic [7:0] top;
    logic [8:0] bottom;
    logic [8:0] left;
    logic [8:0] right;
    logic       valid;
    logic       overflow;
    logic       last;
  } box_t;

  box_t box_q[$];
  int   errors = 0;
  int   rcv_gap_max = 16;

  // predictor state
  bit       dark_map[256][256];
  bit [8:0] box_tops[32], box_bots[32];
  int       row_idx, col_idx, row_dark, line_top, n_boxes;
  bit       in_line, dropped;
  int       thr_line, thr_col, min_h, cfg_w, cfg_h;

  function automatic int clampd(int v);
    return v < 1 ? 1 : (v > 256 ? 256 : v);
  endfunction

  function automatic bit col_light(int c, int t, int b);
    int cnt;
    cnt = 0;
    if (b == t) return 1'b1;
    for (int y = t; y < b && y < 256; y++) if (c < 256 && dark_map[y][c]) cnt++;
    return (cnt * 256) / (b - t) <= thr_col;
  endfunction

  function automatic void predict_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int w, h, lf, rt;
    bit dk;
    box_t o;
    w = clampd(cfg_w);
    h = clampd(cfg_h);
    dk = !(r == 8'hff && g == 8'hff && b == 8'hff);
    if (col_idx > 255) col_idx = 255;
    if (row_idx > 255) row_idx = 255;
    dark_map[row_idx][col_idx] = dk;
    if (dk) row_dark++;
    if (col_idx + 1 < w) begin
      col_idx++;
      return;
    end
    if ((row_dark * 256) / w > thr_line) begin
      if (!in_line) begin
        in_line = 1'b1;
        line_top = row_idx;
      end
    end else if (in_line) begin
      if (row_idx - line_top >= min_h) begin
        if (n_boxes < 32) begin
          box_tops[n_boxes] = 9'(line_top);
          box_bots[n_boxes] = 9'(row_idx);
          n_boxes++;
        end else begin
          dropped = 1'b1;
        end
      end
      in_line = 1'b0;
    end
    col_idx = 0;
    row_dark = 0;
    if (row_idx + 1 < h) begin
      row_idx++;
      return;
    end
    if (n_boxes == 0) begin
      o = '0;
      o.last = 1'b1;
      box_q.push_back(o);
    end
    for (int k = 0; k < n_boxes; k++) begin
      lf = 0;
      rt = w;
      while (lf < w && col_light(lf, box_tops[k], box_bots[k])) lf++;
      while (rt > lf && col_light(rt - 1, box_tops[k], box_bots[k])) rt--;
      o.top = box_tops[k][7:0];
      o.bottom = box_bots[k];
      o.left = 9'(lf);
      o.right = 9'(rt);
      o.valid = 1'b1;
      o.overflow = dropped;
      o.last = (k + 1 == n_boxes);
      box_q.push_back(o);
    end
    row_idx = 0; col_idx = 0; row_dark = 0; in_line = 0;
    line_top = 0; n_boxes = 0; dropped = 0;
  endfunction

  // result checker and receiver stall
  always @(posedge clk_i) begin
    box_t exp_b, act;
    if (out_valid_o && !out_stall_i) begin
      act = '{box_top_o, box_bottom_o, box_left_o, box_right_o,
              box_valid_o, box_overflow_o, box_last_o};
      if (box_q.size() == 0) begin
        $display("%0t: unexpected box, actual %h", $time, act);
        errors++;
      end else begin
        exp_b = box_q.pop_front();
        if (exp_b !== act) begin
          $display("%0t: box mismatch, expected %h actual %h", $time, exp_b, act);
          $display("  top %0d/%0d bot %0d/%0d left %0d/%0d right %0d/%0d v%b/%b o%b/%b l%b/%b",
                   exp_b.top, act.top, exp_b.bottom, act.bottom, exp_b.left, act.left,
                   exp_b.right, act.right, exp_b.valid, act.valid,
                   exp_b.overflow, act.overflow, exp_b.last, act.last);
          errors++;
        end
      end
    end
  end

  initial begin
    int gap;
    forever begin
      @(negedge clk_i);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        gap--;
      end else begin
        out_stall_i <= 1'b0;
        if (out_valid_o) gap = $urandom_range(0, rcv_gap_max);
      end
    end
  end

  int send_gap_max = 16;
  int frames_done = 0;

  // valid stays high between back-to-back transfers and drops on an idle gap
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_i <= r;
    green_i <= g;
    blue_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_pixel(r, g, b);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (box_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [tlbf_pkg::CfgIdxW-1:0] idx, int val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[8:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tlbf_pkg::RegLineThr: thr_line = val & 9'h1ff;
      tlbf_pkg::RegColThr:  thr_col = val & 9'h1ff;
      tlbf_pkg::RegMinH:    min_h = val & 9'h1ff;
      tlbf_pkg::RegWidth:   cfg_w = val & 9'h1ff;
      default:              cfg_h = val & 9'h1ff;
    endcase
  endtask

  task automatic set_geometry(int lt, int ct, int mh, int w, int h);
    drain();
    write_reg(tlbf_pkg::RegLineThr, lt);
    write_reg(tlbf_pkg::RegColThr, ct);
    write_reg(tlbf_pkg::RegMinH, mh);
    write_reg(tlbf_pkg::RegWidth, w);
    write_reg(tlbf_pkg::RegHeight, h);
  endtask

  // each pixel is dark with dark_pct chance, random shade
  task automatic send_frame(int w, int h, int dark_pct);
    logic [7:0] r, g, b;
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        if ($urandom_range(0, 99) < dark_pct) begin
          r = $urandom; g = $urandom; b = $urandom;
          if (r == 8'hff && g == 8'hff && b == 8'hff) b = 8'hfe;
        end else begin
          r = 8'hff; g = 8'hff; b = 8'hff;
        end
        send_pixel(r, g, b);
      end
    end
  endtask

  task automatic test_empty_frame();
    set_geometry(0, 0, 0, 4, 3);
    for (int i = 0; i < 12; i++) send_pixel(8'hff, 8'hff, 8'hff);
  endtask

  task automatic test_channel_extremes();
    // each channel alone below 255, plus all-zero and open line at bottom
    set_geometry(0, 0, 1, 4, 4);
    send_pixel(8'h00, 8'h00, 8'h00); send_pixel(8'hfe, 8'hff, 8'hff);
    send_pixel(8'hff, 8'hfe, 8'hff); send_pixel(8'hff, 8'hff, 8'hfe);
    for (int i = 0; i < 4; i++) send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'hff, 8'hff, 8'h7f); send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'hff, 8'hff, 8'hff); send_pixel(8'hff, 8'hff, 8'hff);
    for (int i = 0; i < 4; i++) send_pixel(8'h80, 8'h01, 8'hff);
  endtask

  task automatic test_full_light_box();
    // min height 0 lets a line of one row form; high column threshold
    set_geometry(0, 300, 0, 2, 3);
    send_pixel(8'h10, 8'h20, 8'h30); send_pixel(8'hff, 8'hff, 8'hff);
    for (int i = 0; i < 4; i++) send_pixel(8'hff, 8'hff, 8'hff);
  endtask

  task automatic test_overflow();
    // alternating rows, width 1: 33 lines in 66 rows
    set_geometry(0, 0, 1, 1, 67);
    for (int y = 0; y < 67; y++)
      if (y % 2 == 0 && y < 66) send_pixel(8'h00, 8'h00, 8'h00);
      else send_pixel(8'hff, 8'hff, 8'hff);
  endtask

  task automatic test_saturation();
    set_geometry(256, 256, 256, 0, 0);
    send_pixel(8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_random_frames();
    int w, h;
    while (1) begin
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 8);
      set_geometry($urandom_range(0, 200), $urandom_range(0, 200),
                   $urandom_range(0, 3), w, h);
      if ($urandom_range(0, 3) == 0) begin
        send_gap_max = 0;
        rcv_gap_max = 0;
      end else begin
        send_gap_max = 16;
        rcv_gap_max = 16;
      end
      send_frame(w, h, $urandom_range(10, 90));
      if (++frames_done >= 6) break;
    end
    send_gap_max = 16;
    rcv_gap_max = 16;
  endtask

  task automatic test_wait_for_results();
    set_geometry(0, 0, 1, 3, 3);
    send_frame(3, 3, 50);
    drain();
    send_frame(3, 3, 50);
  endtask

  initial begin
    thr_line = 0; thr_col = 0; min_h = 5; cfg_w = 256; cfg_h = 256;
    row_idx = 0; col_idx = 0; row_dark = 0; line_top = 0;
    n_boxes = 0; in_line = 0; dropped = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_frame();
    test_channel_extremes();
    test_full_light_box();
    test_overflow();
    test_saturation();
    test_wait_for_results();
    test_random_frames();
    drain();
    if (errors == 0 && box_q.size() == 0) begin
      $display("text_line_box_finder_top verification clean");
    end else begin
      $display("text_line_box_finder_top verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("text_line_box_finder_top verification failed");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
design/tlbf_pkg.sv
design/tlbf_datapath.sv
design/tlbf_ctrl.sv
design/text_line_box_finder_top.sv
verif/text_line_box_finder_top_tb.sv
